@@ rtl/core/text_console_scroll_writer_unit_defines.svh @@
// Assertion macros used by the console writer sequencer (tcsw_back).
`ifndef TEXT_CONSOLE_SCROLL_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_SCROLL_WRITER_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define TCSW_ASSERT_INV(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("console writer invariant violated");

// An implication checked at every clock edge outside reset.
`define TCSW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("console writer implication violated");

`endif

@@ rtl/core/tcsw_pkg.sv @@
// Shared types, codes and constants of the text console writer.
package tcsw_pkg;

    localparam int DEF_COLUMNS     = 80;
    localparam int DEF_LAST_ROW    = 24;
    localparam int DEF_MEM_BYTES   = 16384;
    localparam int DEF_QUEUE_DEPTH = 4;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int OFF_W  = 14;
    localparam int SUM_W  = OFF_W + 1;
    localparam int LIN_W  = COL_W + ROW_W;
    localparam int CELL_BYTES = 2;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ESC   = 8'h1B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;

    typedef enum logic [1:0] {
        OP_CELL = 2'd0,
        OP_FILL = 2'd1,
        OP_REG  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        REG_START_HI = 2'd0,
        REG_START_LO = 2'd1,
        REG_CUR_HI   = 2'd2,
        REG_CUR_LO   = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        KIND_PRINT,
        KIND_CR,
        KIND_LF,
        KIND_DEL,
        KIND_BS
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACT,
        ST_SCR_START,
        ST_SCR_FILL,
        ST_SCR_HI,
        ST_SCR_LO,
        ST_ADDR_LIN,
        ST_ADDR_REL,
        ST_ADDR_ABS,
        ST_CELL,
        ST_DEL_CELL,
        ST_CUR_LO,
        ST_CUR_HI
    } t_bst;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
    } t_cmd;

    typedef struct packed {
        t_op              op;
        logic [OFF_W-1:0] offset;
        t_reg             sel;
        logic [7:0]       data;
        logic             last;
    } t_result;

    // Letters that close an escape sequence.
    function automatic logic ends_escape(input logic [7:0] c);
        logic hit;
        case (c) inside
            "H", "A", "B", "C", "D", "J", "P", "m", "h", "l", "I", "O": hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

@@ rtl/core/text_console_scroll_writer_unit.sv @@
// Top level of the text console writer: input stage, command queue and sequencer.
//
// Input: one console byte per beat on the s channel (tdata bits 7:0). NUL bytes
// and escape sequences up to their closing letter are swallowed without output.
// Output: one display action per beat on the m channel; tuser holds the action
// kind (0 cell write, 1 row fill with spaces, 2 CRTC register write) and the
// CRTC register select, tdata holds the memory offset and the data byte, and
// tlast marks the final beat caused by one input byte.
// The input side classifies bytes at one per cycle into a small command queue,
// so it keeps accepting while the sequencer or the output is busy.
// Per byte the sequencer takes the command, decodes it, works out the cell
// address (a multiply, then two ring reductions) and emits its output beats;
// the worst case (wrap scroll plus line-feed scroll) gives eight beats.
// Reset puts the cursor at row 0, column 0, the screen start at offset 0 and
// empties the queue. When the receiver holds tready low the output register
// keeps its beat and the sequencer waits; input is stalled only once the
// queue is full.
module text_console_scroll_writer_unit #(
    parameter int COLUMNS     = tcsw_pkg::DEF_COLUMNS,
    parameter int LAST_ROW    = tcsw_pkg::DEF_LAST_ROW,
    parameter int MEM_BYTES   = tcsw_pkg::DEF_MEM_BYTES,
    parameter int QUEUE_DEPTH = tcsw_pkg::DEF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_in
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [13:0] mem_offset, [21:14] data_byte, [23:22] zero
    output logic [3:0]  o_m_tuser,   // [1:0] op, [3:2] reg_select
    output logic        o_m_tlast
);

    logic              push_valid;
    logic              push_ready;
    tcsw_pkg::t_cmd    push_cmd;
    logic              pop_valid;
    logic              pop_ready;
    tcsw_pkg::t_cmd    pop_cmd;
    tcsw_pkg::t_result res;

    tcsw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_char       (i_s_tdata),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_cmd   (push_cmd)
    );

    tcsw_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_cmd    (pop_cmd)
    );

    tcsw_back #(
        .COLUMNS   (COLUMNS),
        .LAST_ROW  (LAST_ROW),
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (pop_valid),
        .o_cmd_ready (pop_ready),
        .i_cmd       (pop_cmd),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res       (res)
    );

    assign o_m_tdata = {2'b00, res.data, res.offset};
    assign o_m_tuser = {res.sel, res.op};
    assign o_m_tlast = res.last;

endmodule

@@ rtl/core/tcsw_front.sv @@
// Input stage: drops NUL bytes and escape sequences and classifies the rest.
module tcsw_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_char,
    output logic             o_push_valid,
    input  logic             i_push_ready,
    output tcsw_pkg::t_cmd   o_push_cmd
);

    logic r_esc;
    logic n_esc;
    logic keep;
    logic accept;

    assign o_ready = i_push_ready;
    assign accept  = i_valid && i_push_ready;

    always_comb begin
        n_esc = r_esc;
        keep  = 1'b0;
        if (accept) begin
            if (r_esc) begin
                if (tcsw_pkg::ends_escape(i_char)) begin
                    n_esc = 1'b0;
                end
            end else if (i_char == tcsw_pkg::CHAR_ESC) begin
                n_esc = 1'b1;
            end else if (i_char != tcsw_pkg::CHAR_NUL) begin
                keep = 1'b1;
            end
        end
    end

    always_comb begin
        o_push_cmd.ch = i_char;
        unique case (i_char)
            tcsw_pkg::CHAR_CR:  o_push_cmd.kind = tcsw_pkg::KIND_CR;
            tcsw_pkg::CHAR_LF:  o_push_cmd.kind = tcsw_pkg::KIND_LF;
            tcsw_pkg::CHAR_DEL: o_push_cmd.kind = tcsw_pkg::KIND_DEL;
            tcsw_pkg::CHAR_BS:  o_push_cmd.kind = tcsw_pkg::KIND_BS;
            default:            o_push_cmd.kind = tcsw_pkg::KIND_PRINT;
        endcase
    end

    assign o_push_valid = keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
        end else begin
            r_esc <= n_esc;
        end
    end

endmodule

@@ rtl/core/tcsw_cmd_queue.sv @@
// Small command queue between the classifying front and the executing back.
module tcsw_cmd_queue #(
    parameter int DEPTH = tcsw_pkg::DEF_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  tcsw_pkg::t_cmd i_push_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output tcsw_pkg::t_cmd o_pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tcsw_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_cnt != CNT_FULL);
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

endmodule

@@ rtl/core/tcsw_back.sv @@
// Execution sequencer: cursor, line wrap, scrolling and result generation.
`include "text_console_scroll_writer_unit_defines.svh"

module tcsw_back #(
    parameter int COLUMNS   = tcsw_pkg::DEF_COLUMNS,
    parameter int LAST_ROW  = tcsw_pkg::DEF_LAST_ROW,
    parameter int MEM_BYTES = tcsw_pkg::DEF_MEM_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  tcsw_pkg::t_cmd    i_cmd,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output tcsw_pkg::t_result o_res
);

    localparam int COL_W = tcsw_pkg::COL_W;
    localparam int ROW_W = tcsw_pkg::ROW_W;
    localparam int OFF_W = tcsw_pkg::OFF_W;
    localparam int SUM_W = tcsw_pkg::SUM_W;
    localparam int LIN_W = tcsw_pkg::LIN_W;

    localparam logic [COL_W-1:0] COLS_C    = COL_W'(COLUMNS);
    localparam logic [ROW_W-1:0] LAST_C    = ROW_W'(LAST_ROW);
    localparam logic [SUM_W-1:0] MEM_C     = SUM_W'(MEM_BYTES);
    localparam logic [SUM_W-1:0] ROW_BYTES = SUM_W'(tcsw_pkg::CELL_BYTES * COLUMNS);
    localparam logic [SUM_W-1:0] FILL_REL  =
        SUM_W'((tcsw_pkg::CELL_BYTES * COLUMNS * LAST_ROW) % MEM_BYTES);
    localparam logic [SUM_W-1:0] CELL_STEP = SUM_W'(tcsw_pkg::CELL_BYTES);

    tcsw_pkg::t_bst    r_state, n_state;
    tcsw_pkg::t_bst    r_scr_ret, n_scr_ret;
    tcsw_pkg::t_bst    r_addr_ret, n_addr_ret;
    tcsw_pkg::t_kind   r_kind, n_kind;
    logic [7:0]        r_char, n_char;
    logic [COL_W-1:0]  r_column, n_column;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [OFF_W-1:0]  r_ss, n_ss;
    logic              r_cur_again, n_cur_again;
    logic [LIN_W-1:0]  r_lin, n_lin;
    logic [OFF_W-1:0]  r_rel, n_rel;
    logic [OFF_W-1:0]  r_addr, n_addr;
    logic              r_res_valid, n_res_valid;
    tcsw_pkg::t_result r_res, n_res;

    logic              can_emit;
    logic              emit;
    tcsw_pkg::t_result e_res;
    logic [SUM_W-1:0]  ss_sum, fill_sum, rel_sum, abs_sum, next_sum;
    logic [OFF_W-1:0]  ss_step, fill_addr, rel_mod, abs_mod, next_addr;

    assign can_emit = !r_res_valid || i_res_ready;

    // Each ring position is reduced by one conditional subtract.
    always_comb begin
        ss_sum    = SUM_W'(r_ss) + ROW_BYTES;
        ss_step   = OFF_W'((ss_sum >= MEM_C) ? ss_sum - MEM_C : ss_sum);
        fill_sum  = SUM_W'(r_ss) + FILL_REL;
        fill_addr = OFF_W'((fill_sum >= MEM_C) ? fill_sum - MEM_C : fill_sum);
        rel_sum   = SUM_W'({r_lin, 1'b0});
        rel_mod   = OFF_W'((rel_sum >= MEM_C) ? rel_sum - MEM_C : rel_sum);
        abs_sum   = SUM_W'(r_ss) + SUM_W'(r_rel);
        abs_mod   = OFF_W'((abs_sum >= MEM_C) ? abs_sum - MEM_C : abs_sum);
        next_sum  = SUM_W'(r_addr) + CELL_STEP;
        next_addr = OFF_W'((next_sum >= MEM_C) ? next_sum - MEM_C : next_sum);
    end

    always_comb begin
        n_state     = r_state;
        n_scr_ret   = r_scr_ret;
        n_addr_ret  = r_addr_ret;
        n_kind      = r_kind;
        n_char      = r_char;
        n_column    = r_column;
        n_row       = r_row;
        n_ss        = r_ss;
        n_cur_again = r_cur_again;
        n_lin       = r_lin;
        n_rel       = r_rel;
        n_addr      = r_addr;
        o_cmd_ready = 1'b0;
        emit        = 1'b0;
        e_res.op     = tcsw_pkg::OP_CELL;
        e_res.offset = '0;
        e_res.sel    = tcsw_pkg::REG_START_HI;
        e_res.data   = '0;
        e_res.last   = 1'b0;

        unique case (r_state)
            tcsw_pkg::ST_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_kind      = i_cmd.kind;
                    n_char      = i_cmd.ch;
                    n_cur_again = 1'b0;
                    n_state     = tcsw_pkg::ST_ACT;
                    // Deferred wrap of a line that was filled by the previous byte.
                    if (r_column >= COLS_C) begin
                        n_column = '0;
                        if (r_row <= LAST_C) begin
                            if (r_row < LAST_C) begin
                                n_row = r_row + ROW_W'(1);
                            end else begin
                                n_state   = tcsw_pkg::ST_SCR_START;
                                n_scr_ret = tcsw_pkg::ST_ACT;
                            end
                        end
                    end
                end
            end
            tcsw_pkg::ST_ACT: begin
                n_state    = tcsw_pkg::ST_ADDR_LIN;
                n_addr_ret = tcsw_pkg::ST_CUR_LO;
                unique case (r_kind)
                    tcsw_pkg::KIND_CR: begin
                        n_column = '0;
                    end
                    tcsw_pkg::KIND_LF: begin
                        n_column = '0;
                        if (r_row < LAST_C) begin
                            n_row = r_row + ROW_W'(1);
                        end else begin
                            n_state   = tcsw_pkg::ST_SCR_START;
                            n_scr_ret = tcsw_pkg::ST_ADDR_LIN;
                        end
                    end
                    tcsw_pkg::KIND_DEL: begin
                        if (r_column != '0) begin
                            n_column   = r_column - COL_W'(1);
                            n_addr_ret = tcsw_pkg::ST_DEL_CELL;
                        end
                    end
                    tcsw_pkg::KIND_BS: begin
                        if (r_column != '0) begin
                            n_column    = r_column - COL_W'(1);
                            n_cur_again = 1'b1;
                        end
                    end
                    default: begin
                        n_addr_ret = tcsw_pkg::ST_CELL;
                    end
                endcase
            end
            tcsw_pkg::ST_SCR_START: begin
                n_ss    = ss_step;
                n_state = tcsw_pkg::ST_SCR_FILL;
            end
            tcsw_pkg::ST_SCR_FILL: begin
                if (can_emit) begin
                    emit         = 1'b1;
                    e_res.op     = tcsw_pkg::OP_FILL;
                    e_res.offset = fill_addr;
                    e_res.data   = tcsw_pkg::CHAR_SPACE;
                    n_state      = tcsw_pkg::ST_SCR_HI;
                end
            end
            tcsw_pkg::ST_SCR_HI: begin
                if (can_emit) begin
                    emit       = 1'b1;
                    e_res.op   = tcsw_pkg::OP_REG;
                    e_res.sel  = tcsw_pkg::REG_START_HI;
                    e_res.data = 8'(r_ss[OFF_W-1:9]);
                    n_state    = tcsw_pkg::ST_SCR_LO;
                end
            end
            tcsw_pkg::ST_SCR_LO: begin
                if (can_emit) begin
                    emit       = 1'b1;
                    e_res.op   = tcsw_pkg::OP_REG;
                    e_res.sel  = tcsw_pkg::REG_START_LO;
                    e_res.data = r_ss[8:1];
                    n_state    = r_scr_ret;
                end
            end
            tcsw_pkg::ST_ADDR_LIN: begin
                n_lin   = LIN_W'(r_row) * LIN_W'(COLS_C) + LIN_W'(r_column);
                n_state = tcsw_pkg::ST_ADDR_REL;
            end
            tcsw_pkg::ST_ADDR_REL: begin
                n_rel   = rel_mod;
                n_state = tcsw_pkg::ST_ADDR_ABS;
            end
            tcsw_pkg::ST_ADDR_ABS: begin
                n_addr  = abs_mod;
                n_state = r_addr_ret;
            end
            tcsw_pkg::ST_CELL: begin
                if (can_emit) begin
                    emit         = 1'b1;
                    e_res.op     = tcsw_pkg::OP_CELL;
                    e_res.offset = r_addr;
                    e_res.data   = r_char;
                    n_column     = r_column + COL_W'(1);
                    // The cursor lands on the next cell of the ring.
                    n_addr       = next_addr;
                    n_state      = tcsw_pkg::ST_CUR_LO;
                end
            end
            tcsw_pkg::ST_DEL_CELL: begin
                if (can_emit) begin
                    emit         = 1'b1;
                    e_res.op     = tcsw_pkg::OP_CELL;
                    e_res.offset = r_addr;
                    e_res.data   = tcsw_pkg::CHAR_SPACE;
                    n_cur_again  = 1'b1;
                    n_state      = tcsw_pkg::ST_CUR_LO;
                end
            end
            tcsw_pkg::ST_CUR_LO: begin
                if (can_emit) begin
                    emit       = 1'b1;
                    e_res.op   = tcsw_pkg::OP_REG;
                    e_res.sel  = tcsw_pkg::REG_CUR_LO;
                    e_res.data = r_addr[8:1];
                    n_state    = tcsw_pkg::ST_CUR_HI;
                end
            end
            tcsw_pkg::ST_CUR_HI: begin
                if (can_emit) begin
                    emit       = 1'b1;
                    e_res.op   = tcsw_pkg::OP_REG;
                    e_res.sel  = tcsw_pkg::REG_CUR_HI;
                    e_res.data = 8'(r_addr[OFF_W-1:9]);
                    e_res.last = !r_cur_again;
                    if (r_cur_again) begin
                        n_cur_again = 1'b0;
                        n_state     = tcsw_pkg::ST_CUR_LO;
                    end else begin
                        n_state = tcsw_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = tcsw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_res       = r_res;
        n_res_valid = r_res_valid;
        if (emit) begin
            n_res       = e_res;
            n_res_valid = 1'b1;
        end else if (i_res_ready) begin
            n_res_valid = 1'b0;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcsw_pkg::ST_IDLE;
            r_scr_ret   <= tcsw_pkg::ST_ACT;
            r_addr_ret  <= tcsw_pkg::ST_CUR_LO;
            r_column    <= '0;
            r_row       <= '0;
            r_ss        <= '0;
            r_cur_again <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scr_ret   <= n_scr_ret;
            r_addr_ret  <= n_addr_ret;
            r_column    <= n_column;
            r_row       <= n_row;
            r_ss        <= n_ss;
            r_cur_again <= n_cur_again;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_char <= n_char;
        r_lin  <= n_lin;
        r_rel  <= n_rel;
        r_addr <= n_addr;
        r_res  <= n_res;
    end

    `TCSW_ASSERT_INV(a_column_range, r_column <= COLS_C)
    `TCSW_ASSERT_INV(a_row_range, r_row <= LAST_C)
    `TCSW_ASSERT_INV(a_start_range, SUM_W'(r_ss) < MEM_C)
    `TCSW_ASSERT_IMP(a_last_is_cursor_hi, r_res_valid && r_res.last, r_res.op == tcsw_pkg::OP_REG && r_res.sel == tcsw_pkg::REG_CUR_HI)

endmodule
